[design/lru_key_value_cache_defines.svh]
// Assertion macros for the LRU key-value cache.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define LKV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/lkv_pkg.sv]
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lkv_pkg;

   localparam int KEY_BITS        = 32;
   localparam int VALUE_BITS      = 32;
   localparam int ENTRIES_DEFAULT = 16;
   localparam int CAP_BITS        = 5;
   localparam int ADDR_BITS       = 2;
   localparam int DATA_BITS       = 32;

   localparam logic [CAP_BITS-1:0]  CAPACITY_RESET = 5'd16;
   localparam logic [ADDR_BITS-1:0] ADDR_CAPACITY  = 2'd0;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   typedef struct packed {
      logic                         mode;
      logic [KEY_BITS-1:0]          key;
      logic signed [VALUE_BITS-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                         hit;
      logic signed [VALUE_BITS-1:0] read_value;
      logic                         evicted;
      logic [KEY_BITS-1:0]          evicted_key;
   } rsp_type;

endpackage

[design/lru_key_value_cache.sv]
// Channel   Ports                           Direction  Handshake
// request   start, busy, req_data           in         start & !busy
// response  rsp_valid, rsp_data             out        one-cycle strobe
// config    psel, penable, pwrite, paddr..  in/out     APB access, pready high
//
// One request per cycle; its response strobes after the request register, the
// lookup and update, and the response register.
// The store lookup, LRU rank update and entry write all happen in the same cycle.
// Synchronous active-high reset clears valid bits, ranks and fill count;
// busy is high only during reset. Responses cannot be stalled.
//
// Top level of the LRU key-value cache. Depends on lkv_pkg, lkv_csr,
// lkv_store and lru_key_value_cache_defines.svh.
`timescale 1ns / 1ps

module lru_key_value_cache #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lkv_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output lkv_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lkv_pkg::ADDR_BITS-1:0] paddr,
   input  logic [lkv_pkg::DATA_BITS-1:0] pwdata,
   output logic [lkv_pkg::DATA_BITS-1:0] prdata,
   output logic                          pready
);
   import lkv_pkg::*;

   logic                req_valid_ff;
   logic                req_valid_in;
   req_type             req_data_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;
   logic [CAP_BITS-1:0] capacity;

   assign busy         = reset;
   assign req_valid_in = start && !busy;

   lkv_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   lkv_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (req_valid_ff),
      .op_data   (req_data_ff),
      .capacity  (capacity),
      .op_result (rsp_data_in)
   );

   // advance the request and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // hold payloads
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_data_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "lru_key_value_cache_defines.svh"

   `LKV_ASSERT_NEXT(a_rsp_follows_req, start && !busy, ##1 rsp_valid, "request lost")
   `LKV_ASSERT_NOW(a_rsp_has_req, rsp_valid, $past(start && !busy, 2), "response without request")
   `LKV_ASSERT_NOW(a_miss_reads_zero, rsp_valid && !rsp_data.hit, rsp_data.read_value == '0, "miss returned a value")
   `LKV_ASSERT_NOW(a_evict_on_put_miss, rsp_valid && rsp_data.evicted, !rsp_data.hit && ($past(req_data.mode, 2) == MODE_PUT), "eviction outside a put miss")

endmodule

[design/lkv_csr.sv]
// Configuration register file: holds the capacity register.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lkv_pkg::ADDR_BITS-1:0] paddr,
   input  logic [lkv_pkg::DATA_BITS-1:0] pwdata,
   output logic [lkv_pkg::DATA_BITS-1:0] prdata,
   output logic                          pready,
   output logic [lkv_pkg::CAP_BITS-1:0]  capacity
);
   import lkv_pkg::*;

   logic [CAP_BITS-1:0] capacity_ff;
   logic [CAP_BITS-1:0] capacity_in;
   logic                wr_capacity;

   // decode a completed write to the capacity register
   assign wr_capacity = psel && penable && pwrite && (paddr == ADDR_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_capacity) begin
         capacity_in = pwdata[CAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // read back; unmapped addresses read zero
   always_comb begin
      prdata = '0;
      if (paddr == ADDR_CAPACITY) begin
         prdata = {{(DATA_BITS - CAP_BITS){1'b0}}, capacity_ff};
      end
   end

   assign pready   = 1'b1;
   assign capacity = capacity_ff;

endmodule

[design/lkv_store.sv]
// Entry store: parallel key match, LRU ranks and the entry update.
// Depends on lkv_pkg. Result is combinational from the registered request.
`timescale 1ns / 1ps

module lkv_store #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         op_valid,
   input  lkv_pkg::req_type             op_data,
   input  logic [lkv_pkg::CAP_BITS-1:0] capacity,
   output lkv_pkg::rsp_type             op_result
);
   import lkv_pkg::*;

   localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int UW = $clog2(ENTRIES + 1);
   localparam int CW = (UW > CAP_BITS) ? UW : CAP_BITS;

   // entry storage
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff;
   logic [RW-1:0]         rank_ff  [ENTRIES];
   logic [UW-1:0]         used_ff;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] lru_match;
   logic               hit;
   logic [RW-1:0]      hit_idx;
   logic [RW-1:0]      hit_rank;
   logic [RW-1:0]      lru_rank;
   logic [RW-1:0]      lru_idx;
   logic [RW-1:0]      free_idx;
   logic [RW-1:0]      slot;
   logic [CW-1:0]      cap_ext;
   logic [CW-1:0]      eff_cap;
   logic               full;
   logic               is_put;
   logic               evict;

   // compare the key against every entry at once
   always_comb begin
      lru_rank = RW'(used_ff - UW'(1));
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]     = valid_ff[i] && (key_ff[i] == op_data.key);
         lru_match[i] = valid_ff[i] && (rank_ff[i] == lru_rank);
      end
   end

   assign hit = |match;

   // pick the matching, least recent and first free entries
   always_comb begin
      hit_idx  = '0;
      lru_idx  = '0;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = RW'(i);
         end
         if (lru_match[i]) begin
            lru_idx = RW'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = RW'(i);
         end
      end
   end

   assign hit_rank = rank_ff[hit_idx];

   // clamp capacity into 1..ENTRIES
   always_comb begin
      cap_ext = CW'(capacity);
      priority if (cap_ext == '0) begin
         eff_cap = CW'(1);
      end else if (cap_ext > CW'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full   = CW'(used_ff) >= eff_cap;
   assign is_put = (op_data.mode == MODE_PUT);
   assign evict  = is_put && !hit && full;
   assign slot   = evict ? lru_idx : free_idx;

   // build the response
   always_comb begin
      op_result             = '0;
      op_result.hit         = hit;
      op_result.evicted     = evict;
      if (hit && !is_put) begin
         op_result.read_value = value_ff[hit_idx];
      end
      if (evict) begin
         op_result.evicted_key = key_ff[lru_idx];
      end
   end

   // update valid bits, ranks and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (op_valid) begin
         if (hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (RW'(i) == hit_idx) begin
                  rank_ff[i] <= '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_ff[i] <= rank_ff[i] + RW'(1);
               end
            end
         end else if (is_put) begin
            valid_ff[slot] <= 1'b1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (RW'(i) == slot) begin
                  rank_ff[i] <= '0;
               end else if (valid_ff[i]) begin
                  rank_ff[i] <= rank_ff[i] + RW'(1);
               end
            end
            if (!evict) begin
               used_ff <= used_ff + UW'(1);
            end
         end
      end
   end

   // write key and value words
   always_ff @(posedge clock) begin
      if (op_valid && is_put) begin
         if (hit) begin
            value_ff[hit_idx] <= op_data.write_value;
         end else begin
            key_ff[slot]   <= op_data.key;
            value_ff[slot] <= op_data.write_value;
         end
      end
   end

endmodule

[sim/lkv_checker.sv]
// Response checker for the LRU key-value cache: watches the request, response and APB ports.
// Keeps its own LRU store model and compares every response against it.
// Depends on lkv_pkg only.
`timescale 1ns / 1ps

module lkv_checker #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  lkv_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  lkv_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic                          pready,
   input  logic [lkv_pkg::ADDR_BITS-1:0] paddr,
   input  logic [lkv_pkg::DATA_BITS-1:0] pwdata,
   input  logic [lkv_pkg::DATA_BITS-1:0] prdata,
   output int                            fail_count,
   output int                            pending,
   output int                            results_seen,
   output int                            hits_seen,
   output int                            evictions_seen
);

   import lkv_pkg::*;

   // Model of the store: one slot per entry, age 0 is most recent
   logic [KEY_BITS-1:0]          slot_key[ENTRIES];
   logic signed [VALUE_BITS-1:0] slot_val[ENTRIES];
   bit                           slot_live[ENTRIES];
   int unsigned                  slot_age[ENTRIES];
   int unsigned                  live_count;
   logic [CAP_BITS-1:0]          cap_reg;

   // Responses still owed by the block, oldest first
   rsp_type expected_rsps[$];

   // Apply one request to the store model and return its response
   function automatic rsp_type lru_access(input req_type rq);
      rsp_type     res;
      int          found;
      int          slot;
      int unsigned limit;
      int unsigned age;
      res   = '0;
      found = -1;
      slot  = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && slot_live[i] && slot_key[i] == rq.key) found = i;
      end

      // Hit: update or read, then move to the front
      if (found >= 0) begin
         res.hit = 1'b1;
         if (rq.mode == MODE_PUT) slot_val[found] = rq.write_value;
         else res.read_value = slot_val[found];
         age = slot_age[found];
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && i != found && slot_age[i] < age) slot_age[i]++;
         end
         slot_age[found] = 0;
         return res;
      end

      if (rq.mode == MODE_GET) return res;

      // Clamp the capacity to 1..ENTRIES
      limit = cap_reg;
      if (limit < 1) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;

      // Evict the oldest live entry when full
      if (live_count >= limit) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && (slot < 0 || slot_age[i] > slot_age[slot])) slot = i;
         end
         if (slot >= 0) begin
            res.evicted     = 1'b1;
            res.evicted_key = slot_key[slot];
            slot_live[slot] = 1'b0;
            live_count--;
         end
      end
      if (slot < 0) begin
         for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!slot_live[i]) slot = i;
         end
      end
      if (slot < 0) return res;

      // Insert as most recent
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_live[i]) slot_age[i]++;
      end
      slot_key[slot]  = rq.key;
      slot_val[slot]  = rq.write_value;
      slot_live[slot] = 1'b1;
      slot_age[slot]  = 0;
      live_count++;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
         end
         live_count     = 0;
         cap_reg        = CAPACITY_RESET;
         expected_rsps.delete();
         fail_count     = 0;
         results_seen   = 0;
         hits_seen      = 0;
         evictions_seen = 0;
         pending       <= 0;
      end else begin
         // Check the response against the oldest expectation
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t ns: response with none expected: %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               bad  = 1'b0;
               if (rsp_data.hit !== want.hit) begin
                  $display("%0t ns: hit expected %0b, got %0b", $time, want.hit, rsp_data.hit);
                  bad = 1'b1;
               end
               if (rsp_data.read_value !== want.read_value) begin
                  $display("%0t ns: read_value expected %0d, got %0d",
                           $time, want.read_value, rsp_data.read_value);
                  bad = 1'b1;
               end
               if (rsp_data.evicted !== want.evicted) begin
                  $display("%0t ns: evicted expected %0b, got %0b",
                           $time, want.evicted, rsp_data.evicted);
                  bad = 1'b1;
               end
               if (rsp_data.evicted_key !== want.evicted_key) begin
                  $display("%0t ns: evicted_key expected %h, got %h",
                           $time, want.evicted_key, rsp_data.evicted_key);
                  bad = 1'b1;
               end
               if (bad) fail_count++;
               results_seen++;
               if (want.hit) hits_seen++;
               if (want.evicted) evictions_seen++;
            end
         end

         // Predict the response of each accepted request
         if (start && !busy) expected_rsps.push_back(lru_access(req_data));

         // Track capacity writes and check reads
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == ADDR_CAPACITY) cap_reg = pwdata[CAP_BITS-1:0];
            end else if (paddr == ADDR_CAPACITY && prdata !== DATA_BITS'(cap_reg)) begin
               $display("%0t ns: capacity read expected %h, got %h",
                        $time, DATA_BITS'(cap_reg), prdata);
               fail_count++;
            end
         end
         pending <= expected_rsps.size();
      end
   end

endmodule

[sim/lru_key_value_cache_tb.sv]
// Testbench top for the LRU key-value cache: clock, reset, request and APB stimulus, verdict.
// Depends on lkv_pkg, the lru_key_value_cache RTL and lkv_checker.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

   import lkv_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int POOL_SIZE   = 48;

   logic                 clock;
   logic                 reset   = 1'b1;
   logic                 start   = 1'b0;
   req_type              req_data = '0;
   logic                 psel    = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite  = 1'b0;
   logic [ADDR_BITS-1:0] paddr   = '0;
   logic [DATA_BITS-1:0] pwdata  = '0;
   logic                 busy;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   int fail_count;
   int pending;
   int results_seen;
   int hits_seen;
   int evictions_seen;

   logic [KEY_BITS-1:0] key_pool[POOL_SIZE];
   int                  burst_left  = 1;
   bit                  bursty      = 1'b1;
   int                  phases_run  = 1;
   int                  idle_cycles = 0;

   lru_key_value_cache DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   lkv_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .fail_count     (fail_count),
      .pending        (pending),
      .results_seen   (results_seen),
      .hits_seen      (hits_seen),
      .evictions_seen (evictions_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("** lru_key_value_cache: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One APB transfer to the capacity register, then idle with psel and penable low
   task automatic csr_access(input bit is_write, input logic [DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= ADDR_CAPACITY;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Hold one request until accepted, then insert a gap at the end of a burst when bursty
   task automatic send_request(input req_type rq);
      int gap;
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if (bursty) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Random gets and puts drawn mostly from a small key pool, then drain
   task automatic random_traffic(input int unsigned eff_cap, input int items);
      int      pool_n;
      int      pick;
      req_type rq;
      pool_n = eff_cap + $urandom_range(0, 6);
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(0, 99);
         rq.mode = (pick < 45 || (pick >= 90 && pick < 95)) ? MODE_GET : MODE_PUT;
         rq.key  = (pick < 90) ? key_pool[$urandom_range(0, pool_n - 1)] : $urandom;
         rq.write_value = $urandom;
         send_request(rq);
      end
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Set a capacity, read it back, refresh part of the key pool and run traffic
   task automatic capacity_phase(input logic [CAP_BITS-1:0] cap, input int items);
      logic [DATA_BITS-1:0] word;
      int unsigned          eff_cap;
      word = ($urandom & ~DATA_BITS'(5'h1f)) | DATA_BITS'(cap);
      csr_access(1'b1, word);
      csr_access(1'b0, '0);
      for (int i = 2; i < POOL_SIZE; i++) begin
         if ($urandom_range(0, 3) == 0) key_pool[i] = $urandom;
      end
      bursty  = ($urandom_range(0, 3) != 0);
      eff_cap = (cap == 0) ? 1 : (cap > 16) ? 16 : cap;
      random_traffic(eff_cap, items);
      phases_run++;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Read the capacity reset value
      csr_access(1'b0, '0);

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      // Directed: empty miss, key and value extremes, update, ignored write_value
      send_request(req_type'{MODE_GET, 32'h0000_0000, 32'sh7fff_ffff});
      send_request(req_type'{MODE_PUT, 32'h0000_0000, 32'sh8000_0000});
      send_request(req_type'{MODE_PUT, 32'hffff_ffff, 32'sh7fff_ffff});
      send_request(req_type'{MODE_GET, 32'h0000_0000, 32'sh0000_0000});
      send_request(req_type'{MODE_GET, 32'hffff_ffff, 32'sh8000_0000});
      send_request(req_type'{MODE_PUT, 32'h0000_0000, 32'shffff_ffff});
      send_request(req_type'{MODE_GET, 32'h0000_0000, 32'sh1234_5678});
      send_request(req_type'{MODE_GET, 32'h1234_5678, 32'shffff_ffff});
      send_request(req_type'{MODE_PUT, 32'ha5a5_a5a5, 32'sh5a5a_5a5a});
      send_request(req_type'{MODE_GET, 32'ha5a5_a5a5, 32'sh0000_0000});
      send_request(req_type'{MODE_GET, 32'hffff_ffff, 32'sh0000_0000});
      send_request(req_type'{MODE_PUT, 32'h5a5a_5a5a, 32'sh0000_0000});

      // Fill past the reset capacity, then lower it below the fill level and sweep other settings
      random_traffic(16, 250);
      capacity_phase(5'd3, 125);
      capacity_phase(5'd1, 125);
      capacity_phase(5'd0, 125);
      capacity_phase(5'd31, 125);
      capacity_phase(5'd17, 125);
      capacity_phase(5'd16, 125);
      capacity_phase(5'd8, 125);
      repeat (3) capacity_phase(CAP_BITS'($urandom_range(0, 31)), 125);

      $display("Checked %0d responses over %0d capacity settings (%0d hits, %0d evictions).",
               results_seen, phases_run, hits_seen, evictions_seen);
      if (fail_count == 0) begin
         $display("** lru_key_value_cache: PASSED **");
      end else begin
         $display("** lru_key_value_cache: FAILED **");
      end
      $finish;
   end

endmodule
